// ===== design/qca_pkg.sv =====
// Shared types and constants for the quadrature counter with shaft angles.
package qca_pkg;

  // Configuration register indexes and their values after reset.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ENC_CPT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CPT = 2'd1;

  localparam int ENC_W  = 16;  // encoder counts per turn
  localparam int DIV_W  = 24;  // widest divisor (output counts per turn)
  localparam int ANG_W  = 9;   // angle in whole degrees
  localparam int UNIT_W = 33;  // holds 360 times a remainder below 2^24

  localparam logic [ENC_W-1:0] ENC_CPT_RESET = 16'd44;
  localparam logic [DIV_W-1:0] OUT_CPT_RESET = 24'd3960;
  localparam logic [ANG_W-1:0] FULL_TURN     = 9'd360;

  // Stream payload widths.
  localparam int POS_W      = 32;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 56;

  // Level change codes, bit 0 is channel A and bit 1 is channel B.
  localparam logic [1:0] CHG_A = 2'b01;
  localparam logic [1:0] CHG_B = 2'b10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } qca_state_t;

  typedef struct packed {
    logic idle;
    logic done;
  } qca_stat_t;

endpackage

// ===== design/qca_cmpsub.sv =====
// Shared compare and subtract unit used by every division step.
module qca_cmpsub
  import qca_pkg::*;
(
  input  logic [UNIT_W-1:0] a,
  input  logic [UNIT_W-1:0] b,
  output logic              ge,
  output logic [UNIT_W-1:0] diff
);

  logic [UNIT_W:0] wide;

  // One borrow chain gives both the compare and the difference.
  assign wide = {1'b0, a} - {1'b0, b};
  assign ge   = ~wide[UNIT_W];
  assign diff = wide[UNIT_W-1:0];

endmodule

// ===== design/qca_seq.sv =====
// Sequencer that works out both shaft angles on the shared compare and subtract unit.
module qca_seq
  import qca_pkg::*;
#(
  parameter int CNT_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CNT_W-1:0] position,
  input  logic [ENC_W-1:0] enc_cpt,
  input  logic [DIV_W-1:0] out_cpt,
  input  logic             out_free,
  output qca_stat_t        stat,
  output logic [ANG_W-1:0] enc_angle,
  output logic [ANG_W-1:0] out_angle
);

  localparam int IDX_W = $clog2(CNT_W);

  qca_state_t state, state_next;

  logic [CNT_W-1:0]  mag;       // magnitude, rotated one bit per remainder step
  logic              neg;
  logic              sel;       // 0: encoder angle, 1: output angle
  logic [IDX_W-1:0]  cnt;
  logic [DIV_W-1:0]  rem;
  logic [UNIT_W-1:0] prod;
  logic [UNIT_W-1:0] dsr;
  logic [ANG_W-1:0]  quo;

  logic [DIV_W-1:0]  divisor;
  logic [UNIT_W-1:0] op_a;
  logic [UNIT_W-1:0] op_b;
  logic              ge;
  logic [UNIT_W-1:0] diff;
  logic [ANG_W-1:0]  angle;
  logic              last_mod;
  logic              last_div;

  assign divisor  = sel ? out_cpt : DIV_W'(enc_cpt);
  assign last_mod = (cnt == IDX_W'(CNT_W - 1));
  assign last_div = (cnt == IDX_W'(ANG_W - 1));

  qca_cmpsub u_unit (
    .a    (op_a),
    .b    (op_b),
    .ge   (ge),
    .diff (diff)
  );

  // A zero divisor gives zero; a negative count mirrors a nonzero angle.
  always_comb begin
    if (divisor == '0) begin
      angle = '0;
    end else if (neg && (quo != '0)) begin
      angle = FULL_TURN - quo;
    end else begin
      angle = quo;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_MOD;
      ST_MOD:  if (last_mod) state_next = ST_MUL;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  if (last_div) state_next = ST_FIN;
      ST_FIN:  state_next = sel ? ST_DONE : ST_MOD;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    stat.idle = (state == ST_IDLE);
    stat.done = (state == ST_DONE);
    if (state == ST_MOD) begin
      op_a = UNIT_W'({rem, mag[CNT_W-1]});
      op_b = UNIT_W'(divisor);
    end else begin
      op_a = prod;
      op_b = dsr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          neg <= position[CNT_W-1];
          mag <= position[CNT_W-1] ? (~position + 1'b1) : position;
          sel <= 1'b0;
          cnt <= '0;
          rem <= '0;
        end
      end
      ST_MOD: begin
        // Restoring remainder: one dividend bit enters per cycle.
        mag <= {mag[CNT_W-2:0], mag[CNT_W-1]};
        rem <= ge ? diff[DIV_W-1:0] : op_a[DIV_W-1:0];
        cnt <= last_mod ? '0 : cnt + 1'b1;
      end
      ST_MUL: begin
        prod <= UNIT_W'(rem) * UNIT_W'(FULL_TURN);
        dsr  <= UNIT_W'(divisor) << (ANG_W - 1);
        quo  <= '0;
      end
      ST_DIV: begin
        // The quotient stays below 360, so nine steps cover it.
        if (ge) prod <= diff;
        quo <= {quo[ANG_W-2:0], ge};
        dsr <= dsr >> 1;
        cnt <= last_div ? '0 : cnt + 1'b1;
      end
      ST_FIN: begin
        if (sel) begin
          out_angle <= angle;
        end else begin
          enc_angle <= angle;
        end
        sel <= 1'b1;
        rem <= '0;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/quadrature_counter_with_angle.sv =====
// Top level of the quadrature position counter with encoder and output shaft angles.
//
//   Channel  Direction  Handshake         Payload
//   s        in         s_tvalid/tready   s_tdata: level_a, level_b
//   m        out        m_tvalid/tready   m_tdata: position_count, encoder_angle, output_angle
//   cfg      in         cfg_we            cfg_index, cfg_data
//
// Each request runs on the single compare and subtract unit until the block is ready
// again: COUNT_WIDTH remainder steps, one multiply, nine quotient steps and one
// finishing step per angle, first for the encoder angle and then for the output angle,
// and then a done state that hands the result to the output register.
// Reset is synchronous and active high; it clears the count, the previous levels, the
// primed flag and the output valid, and loads the default counts per turn.
// A finished result sits in the output register while the next request is accepted; the
// sequencer waits with a new result only if that register is still held by a stall.
module quadrature_counter_with_angle
  import qca_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [0] level_a, [1] level_b, rest zero
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] position_count,
                                           // [40:32] encoder_angle,
                                           // [49:41] output_angle, rest zero
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DIV_W-1:0]      cfg_data
);

  localparam int EXT_W = (COUNT_WIDTH > POS_W) ? COUNT_WIDTH : POS_W;

  logic [ENC_W-1:0]       enc_cpt;
  logic [DIV_W-1:0]       out_cpt;
  logic [COUNT_WIDTH-1:0] position;
  logic [COUNT_WIDTH-1:0] position_next;
  logic [1:0]             last_levels;
  logic                   primed;

  logic [1:0]             levels;
  logic                   accept;
  logic                   out_free;
  logic                   handoff;
  qca_stat_t              stat;
  logic [ANG_W-1:0]       enc_angle;
  logic [ANG_W-1:0]       out_angle;
  logic [EXT_W-1:0]       pos_ext;

  assign levels   = s_tdata[1:0];
  assign s_tready = stat.idle;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign handoff  = stat.done && out_free;

  // Configuration writes; an index beyond the register list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      enc_cpt <= ENC_CPT_RESET;
      out_cpt <= OUT_CPT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_ENC_CPT) enc_cpt <= cfg_data[ENC_W-1:0];
      if (cfg_index == REG_OUT_CPT) out_cpt <= cfg_data;
    end
  end

  // A change on A alone counts down when A equals B after it, up otherwise; a change
  // on B alone does the opposite. A change on both pins, or none, keeps the count.
  always_comb begin
    position_next = position;
    if (primed) begin
      unique case (levels ^ last_levels)
        CHG_A: position_next = (levels[0] == levels[1]) ? position - 1'b1
                                                        : position + 1'b1;
        CHG_B: position_next = (levels[0] == levels[1]) ? position + 1'b1
                                                        : position - 1'b1;
        default: position_next = position;
      endcase
    end
  end

  // The first sample after reset only loads the previous levels.
  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      last_levels <= '0;
      primed      <= 1'b0;
    end else if (accept) begin
      position    <= position_next;
      last_levels <= levels;
      primed      <= 1'b1;
    end
  end

  qca_seq #(
    .CNT_W (COUNT_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .position  (position_next),
    .enc_cpt   (enc_cpt),
    .out_cpt   (out_cpt),
    .out_free  (out_free),
    .stat      (stat),
    .enc_angle (enc_angle),
    .out_angle (out_angle)
  );

  // The count is reported as its low 32 bits after sign extension.
  assign pos_ext = EXT_W'($signed(position));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (handoff) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (handoff) begin
      m_tdata <= OUT_DATA_W'({out_angle, enc_angle, pos_ext[POS_W-1:0]});
    end
  end

endmodule

// ===== design/qca_checker.sv =====
// Port-level checker for the quadrature counter, bound to the top level.
module qca_checker
  import qca_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // An accepted request keeps the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted again right after a request");

  // Both angles are whole degrees below a full turn.
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[40:32] < FULL_TURN) && (m_tdata[49:41] < FULL_TURN))
    else $error("angle outside 0 to 359 degrees");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

endmodule

bind quadrature_counter_with_angle qca_checker u_qca_checker (.*);
